### hdl/kcq_pkg.sv
package kcq_pkg;

  localparam int PIX_AW     = 16;
  localparam int PIX_DEPTH  = 65536;
  localparam int NCLUST     = 16;
  localparam int CLW        = 4;
  localparam int SUMW       = 24;
  localparam int CNTW       = 17;
  localparam int DISTW      = 18;

  localparam logic [1:0] CFG_CLUSTER_COUNT  = 2'd0;
  localparam logic [1:0] CFG_MAX_ITERATIONS = 2'd1;
  localparam logic [1:0] CFG_INIT_STRIDE    = 2'd2;
  localparam logic [1:0] CFG_GRAY_OUTPUT    = 2'd3;

  localparam logic [1:0] ST_DONE      = 2'd0;
  localparam logic [1:0] ST_READ      = 2'd1;
  localparam logic [1:0] ST_BAD_INDEX = 2'd2;
  localparam logic [1:0] ST_DONE_DROP = 2'd3;

  typedef struct packed {
    logic load;
    logic rd_start;
    logic init_start;
    logic init_rd;
    logic init_wr;
    logic pass_start;
    logic px_rd;
    logic measure;
    logic acc;
    logic div_start;
    logic upd_wr;
    logic pass_end;
    logic resp_done;
    logic resp_read;
  } kcq_cmd_t;

  typedef struct packed {
    logic i_last;
    logic p_last;
    logic div_done;
    logic more;
    logic out_free;
  } kcq_sts_t;

endpackage

### hdl/kcq_div.sv
module kcq_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [23:0] dividend,
  input  logic [16:0] divisor,
  output logic [7:0]  quo,
  output logic        done
);
  import kcq_pkg::*;

  logic [23:0] rem_r;
  logic [23:0] dsh_r;
  logic [7:0]  q_r;
  logic [3:0]  cnt_r;
  logic        busy_r;
  logic        ge;

  assign ge   = rem_r >= dsh_r;
  assign quo  = q_r;
  assign done = !busy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= 4'd0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= 4'd8;
    end else if (busy_r) begin
      cnt_r <= cnt_r - 4'd1;
      if (cnt_r == 4'd1) busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= dividend;
      dsh_r <= {divisor, 7'b0};
      q_r   <= 8'd0;
    end else if (busy_r) begin
      if (ge) rem_r <= rem_r - dsh_r;
      q_r   <= {q_r[6:0], ge};
      dsh_r <= {1'b0, dsh_r[23:1]};
    end
  end

endmodule

### hdl/kcq_datapath.sv
module kcq_datapath (
  input  logic             clk,
  input  logic             rst_n,
  input  kcq_pkg::kcq_cmd_t cmd,
  output kcq_pkg::kcq_sts_t sts,
  input  logic             cfg_we,
  input  logic [1:0]       cfg_idx,
  input  logic [15:0]      cfg_wdata,
  input  logic [7:0]       in_red,
  input  logic [7:0]       in_green,
  input  logic [7:0]       in_blue,
  input  logic [15:0]      in_index,
  input  logic             out_ready,
  output logic             out_valid,
  output logic [39:0]      out_data,
  output logic [1:0]       out_status
);
  import kcq_pkg::*;

  logic [4:0]  cc_r;
  logic [7:0]  mi_r;
  logic [15:0] st_r;
  logic        gray_r;

  logic [16:0] pc_r;
  logic        ovf_r;
  logic [7:0]  pass_r;
  logic        changed_r;
  logic [3:0]  i_r;
  logic [15:0] p_r;
  logic [3:0]  best_r;
  logic [DISTW-1:0] bestd_r;
  logic        bad_r;

  logic [23:0] pix_mem [PIX_DEPTH];
  logic [3:0]  lab_mem [PIX_DEPTH];
  logic [23:0] px_q_r;
  logic [3:0]  lab_q_r;

  logic [23:0]     ctr_r [NCLUST];
  logic [SUMW-1:0] sum_r [NCLUST][3];
  logic [CNTW-1:0] cnt_r [NCLUST];

  logic        out_valid_r;
  logic [39:0] out_data_r;
  logic [1:0]  out_status_r;

  logic [4:0]  k_eff;
  logic [7:0]  it_eff;
  logic [16:0] pc_eff;
  logic        pix_we;
  logic        pix_re;
  logic [15:0] pix_ra;
  logic [19:0] prod;
  logic [16:0] pc_m1;
  logic [15:0] init_at;
  logic [3:0]  ca;
  logic [3:0]  sa;
  logic [23:0] csel;
  logic signed [8:0]  dr, dg, db;
  logic signed [17:0] sr, sg, sb;
  logic [DISTW-1:0] sqd;
  logic [7:0]  q0, q1, q2;
  logic [2:0]  dn;
  logic [23:0] nc;

  assign k_eff  = (cc_r == 5'd0) ? 5'd1 : ((cc_r > 5'd16) ? 5'd16 : cc_r);
  assign it_eff = (mi_r == 8'd0) ? 8'd1 : mi_r;
  assign pc_eff = (pass_r != 8'd0) ? 17'd0 : pc_r;
  assign pix_we = cmd.load && !pc_eff[16];
  assign pix_re = cmd.init_rd || cmd.px_rd;
  assign prod   = {16'd0, i_r} * {4'd0, st_r};
  assign pc_m1  = pc_r - 17'd1;
  assign init_at = (prod > {3'b0, pc_m1}) ? pc_m1[15:0] : prod[15:0];
  assign pix_ra = cmd.init_rd ? init_at : p_r;

  assign ca   = cmd.resp_read ? lab_q_r : i_r;
  assign sa   = cmd.acc ? best_r : i_r;
  assign csel = ctr_r[ca];

  assign dr = $signed({1'b0, px_q_r[23:16]}) - $signed({1'b0, csel[23:16]});
  assign dg = $signed({1'b0, px_q_r[15:8]})  - $signed({1'b0, csel[15:8]});
  assign db = $signed({1'b0, px_q_r[7:0]})   - $signed({1'b0, csel[7:0]});
  assign sr = dr * dr;
  assign sg = dg * dg;
  assign sb = db * db;
  assign sqd = $unsigned(sr) + $unsigned(sg) + $unsigned(sb);

  assign nc = (cnt_r[i_r] == '0) ? 24'd0 : {q0, q1, q2};

  assign sts.i_last   = ({1'b0, i_r} == (k_eff - 5'd1));
  assign sts.p_last   = ({1'b0, p_r} == pc_m1);
  assign sts.div_done = &dn;
  assign sts.more     = (({1'b0, pass_r} + 9'd1) < {1'b0, it_eff}) && changed_r;
  assign sts.out_free = !out_valid_r || out_ready;

  assign out_valid  = out_valid_r;
  assign out_data   = out_data_r;
  assign out_status = out_status_r;

  kcq_div u_div_r (.clk, .rst_n, .start(cmd.div_start), .dividend(sum_r[i_r][0]),
                   .divisor(cnt_r[i_r]), .quo(q0), .done(dn[0]));
  kcq_div u_div_g (.clk, .rst_n, .start(cmd.div_start), .dividend(sum_r[i_r][1]),
                   .divisor(cnt_r[i_r]), .quo(q1), .done(dn[1]));
  kcq_div u_div_b (.clk, .rst_n, .start(cmd.div_start), .dividend(sum_r[i_r][2]),
                   .divisor(cnt_r[i_r]), .quo(q2), .done(dn[2]));

  always_ff @(posedge clk) begin
    if (pix_we) pix_mem[pc_eff[15:0]] <= {in_red, in_green, in_blue};
    if (pix_re) px_q_r <= pix_mem[pix_ra];
  end

  always_ff @(posedge clk) begin
    if (cmd.acc) lab_mem[p_r] <= best_r;
    if (cmd.rd_start) lab_q_r <= lab_mem[in_index];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cc_r   <= 5'd4;
      mi_r   <= 8'd10;
      st_r   <= 16'd1;
      gray_r <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_CLUSTER_COUNT:  cc_r   <= cfg_wdata[4:0];
        CFG_MAX_ITERATIONS: mi_r   <= cfg_wdata[7:0];
        CFG_INIT_STRIDE:    st_r   <= cfg_wdata;
        CFG_GRAY_OUTPUT:    gray_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r      <= 17'd0;
      ovf_r     <= 1'b0;
      pass_r    <= 8'd0;
      changed_r <= 1'b0;
    end else begin
      if (cmd.load) begin
        pass_r <= 8'd0;
        if (pc_eff[16]) begin
          pc_r  <= pc_eff;
          ovf_r <= 1'b1;
        end else begin
          pc_r  <= pc_eff + 17'd1;
          ovf_r <= (pass_r != 8'd0) ? 1'b0 : ovf_r;
        end
      end
      if (cmd.pass_start) changed_r <= 1'b0;
      if (cmd.upd_wr && (nc != ctr_r[i_r])) changed_r <= 1'b1;
      if (cmd.pass_end) pass_r <= pass_r + 8'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.init_start || cmd.px_rd || cmd.acc) i_r <= 4'd0;
    else if (cmd.init_wr || cmd.measure || cmd.upd_wr) i_r <= i_r + 4'd1;
    if (cmd.pass_start) p_r <= 16'd0;
    else if (cmd.acc) p_r <= p_r + 16'd1;
    if (cmd.rd_start) bad_r <= (pass_r == 8'd0) || ({1'b0, in_index} >= pc_r);
    if (cmd.measure && ((i_r == 4'd0) || (sqd < bestd_r))) begin
      best_r  <= i_r;
      bestd_r <= sqd;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.init_wr) ctr_r[i_r] <= px_q_r;
    else if (cmd.upd_wr) ctr_r[i_r] <= nc;
  end

  always_ff @(posedge clk) begin
    if (cmd.pass_start) begin
      for (int n = 0; n < NCLUST; n++) begin
        cnt_r[n]    <= '0;
        sum_r[n][0] <= '0;
        sum_r[n][1] <= '0;
        sum_r[n][2] <= '0;
      end
    end else if (cmd.acc) begin
      cnt_r[sa]    <= cnt_r[sa] + 17'd1;
      sum_r[sa][0] <= sum_r[sa][0] + {16'd0, px_q_r[23:16]};
      sum_r[sa][1] <= sum_r[sa][1] + {16'd0, px_q_r[15:8]};
      sum_r[sa][2] <= sum_r[sa][2] + {16'd0, px_q_r[7:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.resp_done || cmd.resp_read) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.resp_done) begin
      out_status_r <= ovf_r ? ST_DONE_DROP : ST_DONE;
      out_data_r   <= {4'd0, pass_r, 28'd0};
    end else if (cmd.resp_read) begin
      if (bad_r) begin
        out_status_r <= ST_BAD_INDEX;
        out_data_r   <= 40'd0;
      end else begin
        out_status_r <= ST_READ;
        out_data_r   <= {12'd0, lab_q_r, gray_r ? csel[23:16] : csel[7:0],
                         gray_r ? csel[23:16] : csel[15:8], csel[23:16]};
      end
    end
  end

  a_pc_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pc_r <= 17'(PIX_DEPTH)) else $error("pixel count beyond store");
  a_ovf_full: assert property (@(posedge clk) disable iff (!rst_n)
    ovf_r |-> pc_r[16]) else $error("drop flagged with room left");
  a_pass_step: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.pass_end |=> pass_r == $past(pass_r) + 8'd1) else $error("pass count slip");

endmodule

### hdl/kcq_ctrl.sv
module kcq_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_mode,
  input  logic              in_last,
  output logic              in_ready,
  input  kcq_pkg::kcq_sts_t  sts,
  output kcq_pkg::kcq_cmd_t  cmd
);
  import kcq_pkg::*;

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_RD       = 4'd1;
  localparam logic [3:0] S_INIT_A   = 4'd2;
  localparam logic [3:0] S_INIT_W   = 4'd3;
  localparam logic [3:0] S_PASS_S   = 4'd4;
  localparam logic [3:0] S_PX_RD    = 4'd5;
  localparam logic [3:0] S_DIST     = 4'd6;
  localparam logic [3:0] S_ACC      = 4'd7;
  localparam logic [3:0] S_UPD_S    = 4'd8;
  localparam logic [3:0] S_UPD_WAIT = 4'd9;
  localparam logic [3:0] S_UPD_W    = 4'd10;
  localparam logic [3:0] S_PASS_END = 4'd11;
  localparam logic [3:0] S_DONE     = 4'd12;

  logic [3:0] state_r, state_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (!in_mode) begin
            cmd.load = 1'b1;
            if (in_last) begin
              cmd.init_start = 1'b1;
              state_nxt      = S_INIT_A;
            end
          end else begin
            cmd.rd_start = 1'b1;
            state_nxt    = S_RD;
          end
        end
      end
      S_RD: begin
        if (sts.out_free) begin
          cmd.resp_read = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      S_INIT_A: begin
        cmd.init_rd = 1'b1;
        state_nxt   = S_INIT_W;
      end
      S_INIT_W: begin
        cmd.init_wr = 1'b1;
        state_nxt   = sts.i_last ? S_PASS_S : S_INIT_A;
      end
      S_PASS_S: begin
        cmd.pass_start = 1'b1;
        state_nxt      = S_PX_RD;
      end
      S_PX_RD: begin
        cmd.px_rd = 1'b1;
        state_nxt = S_DIST;
      end
      S_DIST: begin
        cmd.measure = 1'b1;
        if (sts.i_last) state_nxt = S_ACC;
      end
      S_ACC: begin
        cmd.acc   = 1'b1;
        state_nxt = sts.p_last ? S_UPD_S : S_PX_RD;
      end
      S_UPD_S: begin
        cmd.div_start = 1'b1;
        state_nxt     = S_UPD_WAIT;
      end
      S_UPD_WAIT: begin
        if (sts.div_done) state_nxt = S_UPD_W;
      end
      S_UPD_W: begin
        cmd.upd_wr = 1'b1;
        state_nxt  = sts.i_last ? S_PASS_END : S_UPD_S;
      end
      S_PASS_END: begin
        cmd.pass_end = 1'b1;
        state_nxt    = sts.more ? S_PASS_S : S_DONE;
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.resp_done = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

  a_resp_free: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.resp_done || cmd.resp_read) |-> sts.out_free) else $error("result overwrite");
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.load, cmd.rd_start, cmd.init_wr, cmd.acc, cmd.upd_wr,
              cmd.resp_done, cmd.resp_read})) else $error("command clash");
  a_resp_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.resp_done || cmd.resp_read) |=> state_r == S_IDLE) else $error("no return to idle");

endmodule

### hdl/kmeans_color_quantizer_unit.sv
// K-means color quantizer.
// in_*: one beat per pixel load (in_tuser=0, RGB in tdata, in_tlast on the final
// pixel) or per result read (in_tuser=1, pixel index in tdata[39:24]).
// out_*: one beat per read and one beat when clustering finishes; out_tuser is
// the status (done, read data, bad index, done with pixels dropped).
// cfg_*: register writes, always ready; write only while the block is idle.
// Loads are taken back to back. A read registers its label and index check,
// then answers from S_RD once the output beat is free. During clustering after
// the final pixel, the distance unit checks one center per cycle and the mean
// of each center takes an 8-step divide. No input is taken during clustering.
// Reset clears the pixel count, the pass count and the output valid flag; the
// pixel and label stores are not cleared.
// When out_tready is low the result beat holds. Loads are still taken; a read,
// or the final load once clustering ends, waits with in_tready low until that
// beat has gone.
module kmeans_color_quantizer_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // red, green, blue, index
  input  logic        in_tuser,   // mode
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // out_red, out_green, out_blue, label, iterations_used
  output logic [1:0]  out_tuser,  // status
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import kcq_pkg::*;

  kcq_cmd_t cmd;
  kcq_sts_t sts;

  assign cfg_ready = 1'b1;

  kcq_ctrl u_ctrl (
    .clk, .rst_n,
    .in_valid (in_tvalid),
    .in_mode  (in_tuser),
    .in_last  (in_tlast),
    .in_ready (in_tready),
    .sts, .cmd
  );

  kcq_datapath u_dp (
    .clk, .rst_n, .cmd, .sts,
    .cfg_we     (cfg_valid),
    .cfg_idx    (cfg_index),
    .cfg_wdata  (cfg_data),
    .in_red     (in_tdata[7:0]),
    .in_green   (in_tdata[15:8]),
    .in_blue    (in_tdata[23:16]),
    .in_index   (in_tdata[39:24]),
    .out_ready  (out_tready),
    .out_valid  (out_tvalid),
    .out_data   (out_tdata),
    .out_status (out_tuser)
  );

endmodule
